// ===== sv/finv_pkg.sv =====
// shared types, constants and the field multiply for the field inverse pipeline
package finv_pkg;

    // symbol width m of GF(2^m), 3 to 12
    localparam int SYM_BITS   = 8;
    localparam int POLY_BITS  = SYM_BITS + 1;
    // one squaring stage per exponent bit plus a closing squaring stage
    localparam int NUM_STAGES = SYM_BITS;

    localparam logic [POLY_BITS-1:0] POLY_RESET = POLY_BITS'(285);

    typedef logic [SYM_BITS-1:0]  sym_t;
    typedef logic [POLY_BITS-1:0] poly_t;

    localparam sym_t SYM_ONE = sym_t'(1);

    // item state carried down the pipeline
    typedef struct packed {
        logic valid;
        sym_t sq;
        sym_t acc;
    } stage_t;

    // polynomial product of a and b reduced by x^m + taps, msb-first shift-xor
    function automatic sym_t gf_mul(sym_t a, sym_t b, sym_t taps);
        logic [SYM_BITS:0] acc;
        acc = '0;
        for (int i = SYM_BITS - 1; i >= 0; i--) begin
            acc = {acc[SYM_BITS-1:0], 1'b0};
            if (acc[SYM_BITS]) begin
                acc = acc ^ {1'b1, taps};
            end
            if (b[i]) begin
                acc = acc ^ {1'b0, a};
            end
        end
        return acc[SYM_BITS-1:0];
    endfunction

endpackage

// ===== sv/finv_stage.sv =====
// one pipeline stage: squares the running power and folds it into the product
module finv_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  finv_pkg::sym_t  taps,
    input  finv_pkg::stage_t in_stage,
    output logic            in_ready,
    output finv_pkg::stage_t out_stage,
    input  logic            out_ready
);
    import finv_pkg::*;

    logic valid_reg;
    sym_t sq_reg;
    sym_t acc_reg;
    sym_t sq_next;
    sym_t acc_next;

    // stage moves when empty or when downstream takes its item
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sq_next  = gf_mul(in_stage.sq, in_stage.sq, taps);
        acc_next = gf_mul(in_stage.acc, in_stage.sq, taps);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_stage.valid) begin
            sq_reg  <= sq_next;
            acc_reg <= acc_next;
        end
    end

    assign out_stage = '{valid: valid_reg, sq: sq_reg, acc: acc_reg};

endmodule

// ===== sv/gf_field_inverse_top.sv =====
// top level of the gf(2^m) field inverse pipeline
// an accepted item passes through all SYM_BITS stage registers in turn before it shows at m_valid
// throughput: one item per cycle while m_ready stays high; each stage holds one field multiply pair
// a stall at m_ready backs up stage by stage, bubbles are squeezed out as it does
// reset (aresetn low, synchronous) empties every stage; reduction taps return to 0x1d (polynomial 0x11d)
// the polynomial write port is always ready and takes effect on the next cycle
module gf_field_inverse_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // polynomial write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  finv_pkg::poly_t      cfg_data,
    // input item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  finv_pkg::sym_t       s_value,
    // result item channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output finv_pkg::sym_t       m_inverse
);
    import finv_pkg::*;

    // only the low m bits are feedback taps, x^m is always present
    sym_t prim_taps_reg;

    stage_t stage_in  [NUM_STAGES];
    stage_t stage_out [NUM_STAGES];
    logic   stage_in_ready  [NUM_STAGES];
    logic   stage_out_ready [NUM_STAGES];
    logic [NUM_STAGES-1:0] stage_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prim_taps_reg <= POLY_RESET[SYM_BITS-1:0];
        end else if (cfg_valid && cfg_ready) begin
            prim_taps_reg <= cfg_data[SYM_BITS-1:0];
        end
    end

    // stages 0..m-2: sq runs x, x^2, x^4 ... while acc gathers x^(2^(m-1)-1)
    // last stage squares acc, giving x^(2^m-2), zero stays zero
    always_comb begin
        stage_in[0] = '{valid: s_valid, sq: s_value, acc: SYM_ONE};
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (k == NUM_STAGES - 1) begin
                stage_in[k] = '{valid: stage_out[k-1].valid, sq: stage_out[k-1].acc,
                                acc: SYM_ONE};
            end else begin
                stage_in[k] = stage_out[k-1];
            end
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (k == NUM_STAGES - 1) begin
                stage_out_ready[k] = m_ready;
            end else begin
                stage_out_ready[k] = stage_in_ready[k+1];
            end
            stage_valid[k] = stage_out[k].valid;
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        finv_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .taps      (prim_taps_reg),
            .in_stage  (stage_in[g]),
            .in_ready  (stage_in_ready[g]),
            .out_stage (stage_out[g]),
            .out_ready (stage_out_ready[g])
        );
    end

    assign s_ready   = stage_in_ready[0];
    assign m_valid   = stage_out[NUM_STAGES-1].valid;
    assign m_inverse = stage_out[NUM_STAGES-1].sq;

    // back pressure reaches the input only when every stage is full
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (stage_valid == {NUM_STAGES{1'b1}}))
        else $error("input blocked while a stage is empty");

    // an open output never blocks the input
    a_open_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked with output ready");

    // an item appears in the second stage only after sitting in the first
    a_no_invented_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stage_valid[1]) |-> $past(stage_valid[0]))
        else $error("item appeared without a predecessor");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> stage_valid[0])
        else $error("accepted item lost at pipeline entry");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the gf(2^m) field inverse pipeline
`timescale 1ns / 100ps

module testbench;
    import finv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int TAIL_CYCLES = 4 * NUM_STAGES;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // polynomial write channel
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    poly_t cfg_data = POLY_RESET;

    // input item channel
    logic s_valid = 1'b0;
    logic s_ready;
    sym_t s_value = '0;

    // result item channel
    logic m_valid;
    logic m_ready = 1'b0;
    sym_t m_inverse;

    // items waiting to be offered, and inverses waiting to come out
    sym_t value_backlog[$];
    sym_t awaited_inverses[$];

    // polynomial the block should be reducing by right now
    poly_t field_poly = POLY_RESET;

    // idle rates in percent, set between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // receiver hold-off: a request count from the sequencer, served by its own counter
    int squeeze_reqs = 0;
    int squeeze_served = 0;
    int squeeze_left = 0;

    int mismatches = 0;
    int cycle_count = 0;

    gf_field_inverse_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_inverse (m_inverse)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // product in the ring gf(2)[x] / (x^m + taps), lsb-first with xtime on the multiplicand
    function automatic sym_t field_mul(sym_t a, sym_t b, poly_t poly);
        sym_t prod;
        sym_t term;
        prod = '0;
        term = a;
        for (int i = 0; i < SYM_BITS; i++) begin
            if (b[i]) begin
                prod = prod ^ term;
            end
            // x^m folds back onto the low taps; bit m of the register is never looked at
            if (term[SYM_BITS-1]) begin
                term = (term << 1) ^ poly[SYM_BITS-1:0];
            end else begin
                term = term << 1;
            end
        end
        return prod;
    endfunction

    // x^(2^m - 2) as the product of x^2, x^4, ..., x^(2^(m-1)); zero maps to zero
    function automatic sym_t predict_inverse(sym_t x, poly_t poly);
        sym_t power;
        sym_t result;
        power = x;
        result = SYM_ONE;
        for (int k = 1; k < SYM_BITS; k++) begin
            power = field_mul(power, power, poly);
            result = field_mul(result, power, poly);
        end
        return result;
    endfunction

    // random field element, weighted toward the corners
    function automatic sym_t draw_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return SYM_ONE;
            3: return SYM_ONE << $urandom_range(SYM_BITS - 1);
            4: return ~(SYM_ONE << $urandom_range(SYM_BITS - 1));
            default: return sym_t'($urandom);
        endcase
    endfunction

    // driver: offers the backlog one item at a time, predicts each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_value <= '0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_inverses.push_back(predict_inverse(s_value, field_poly));
            end
            // a held item stays put until it is taken
            if (!s_valid || s_ready) begin
                if (value_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_value <= value_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                    s_value <= sym_t'($urandom);
                end
            end
        end
    end

    // hold-off counter: each new request keeps m_ready low for a long stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            squeeze_left <= 0;
        end else if (squeeze_reqs != squeeze_served) begin
            squeeze_served <= squeeze_reqs;
            squeeze_left <= SQUEEZE_CYCLES;
        end else if (squeeze_left != 0) begin
            squeeze_left <= squeeze_left - 1;
        end
    end

    // monitor: compares each taken result against the oldest prediction, drives m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_inverses.size() == 0) begin
                    $error("inverse: no item pending, got %0h", m_inverse);
                    mismatches <= mismatches + 1;
                end else if (awaited_inverses[0] !== m_inverse) begin
                    $error("inverse: expected %0h, got %0h", awaited_inverses[0], m_inverse);
                    mismatches <= mismatches + 1;
                    void'(awaited_inverses.pop_front());
                end else begin
                    void'(awaited_inverses.pop_front());
                end
            end
            m_ready <= (squeeze_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one polynomial setting: optional write while idle, then items, then drain
    task automatic run_phase(poly_t poly, bit write_poly, bit directed, int tx_pct,
                             int rx_pct, bit squeeze, int count);
        if (write_poly) begin
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data <= poly;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            cfg_data <= poly_t'($urandom);
            field_poly <= poly;
        end
        @(negedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (directed) begin
            // zero, one, all ones, each single bit, two single-bit complements, alternating patterns, three
            value_backlog.push_back('0);
            value_backlog.push_back(SYM_ONE);
            value_backlog.push_back('1);
            for (int b = 1; b < SYM_BITS; b++) begin
                value_backlog.push_back(SYM_ONE << b);
            end
            value_backlog.push_back(~SYM_ONE);
            value_backlog.push_back({(SYM_BITS + 1) / 2 {2'b01}});
            value_backlog.push_back({(SYM_BITS + 1) / 2 {2'b10}});
            value_backlog.push_back(~(SYM_ONE << (SYM_BITS - 1)));
            value_backlog.push_back(sym_t'(3));
        end
        for (int n = 0; n < count; n++) begin
            value_backlog.push_back(draw_value());
        end
        // hold the receiver while the sender keeps pushing, so the pipe backs up
        if (squeeze) begin
            squeeze_reqs = squeeze_reqs + 1;
        end
        do @(negedge aclk);
        while (value_backlog.size() != 0 || s_valid || awaited_inverses.size() != 0);
    endtask

    // sequencer
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver heavily; reset polynomial first, then extremes
        run_phase(POLY_RESET, 1'b0, 1'b1, 25, 85, 1'b0, 60);
        run_phase(poly_t'(0), 1'b1, 1'b0, 25, 85, 1'b0, 60);      // bit m clear, no taps
        run_phase(poly_t'(9'h1ff), 1'b1, 1'b0, 25, 85, 1'b0, 60);  // every tap set

        // the other way round: non-primitive and alternative primitive polynomials
        run_phase(poly_t'(9'h11b), 1'b1, 1'b0, 85, 25, 1'b0, 60);
        run_phase(poly_t'(9'h187), 1'b1, 1'b0, 85, 25, 1'b0, 60);
        run_phase(poly_t'(9'h02b), 1'b1, 1'b0, 85, 25, 1'b0, 60);  // taps only, x^m assumed

        // no idling, with long receiver hold-offs
        run_phase(poly_t'(9'h12d), 1'b1, 1'b0, 0, 0, 1'b1, 60);
        run_phase(poly_t'($urandom_range(511)), 1'b1, 1'b0, 0, 0, 1'b1, 60);

        // any stray result shows up here
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && awaited_inverses.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
